// File: hdl/mte_pkg.sv
// Shared types and constants for the memory access trace trigger.
// No dependencies; imported by every module of the block.
`default_nettype none

package mte_pkg;

  // Item kinds on the input channel
  typedef enum logic [1:0] {
    MODE_ACCESS     = 2'd0,
    MODE_TICK       = 2'd1,
    MODE_LOAD_DATA  = 2'd2,
    MODE_LOAD_RANGE = 2'd3
  } mode_t;

  // Configuration register indexes
  localparam int CFG_INDEX_W = 3;
  localparam logic [CFG_INDEX_W-1:0] CFG_MONITOR_STACK  = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_CATCH_ABOVE    = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_TICK_THRESHOLD = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_DATA_COUNT     = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_RANGE_COUNT    = 3'd4;

  // Low address bits ignored by the stack region match
  localparam logic [63:0] STACK_REGION_MASK = 64'h0000_0000_0003_FFFF;

  // Record queue between classifier and output side
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  // One trace record
  typedef struct packed {
    logic [63:0] pc;
    logic [63:0] address;
    logic [63:0] value;
    logic        write;
  } trace_rec_t;

  // Classifier to queue transaction
  typedef struct packed {
    logic       push;
    trace_rec_t rec;
  } rec_push_t;

endpackage

`default_nettype wire

// File: hdl/mte_front.sv
// Front end: configuration registers, tick counter, trigger tables and the
// per-access classifier with one stage register. Depends on mte_pkg.
`default_nettype none

module mte_front #(
  parameter int DATA_SLOTS  = 8,
  parameter int RANGE_SLOTS = 8
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_accept,
  input  wire logic [1:0]                      in_mode,
  input  wire logic [63:0]                     in_access_address,
  input  wire logic [63:0]                     in_access_value,
  input  wire logic [63:0]                     in_stack_pointer,
  input  wire logic [63:0]                     in_program_counter,
  input  wire logic                            in_is_write,
  input  wire logic [2:0]                      in_slot,
  input  wire logic [63:0]                     in_range_end,
  input  wire logic                            cfg_wr,
  input  wire logic [mte_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [63:0]                     cfg_data,
  output mte_pkg::rec_push_t                   q_push
);
  import mte_pkg::*;

  mode_t       mode;
  logic        monitor_stack_r;
  logic [63:0] catch_above_r;
  logic [31:0] tick_threshold_r;
  logic [3:0]  data_count_r;
  logic [3:0]  range_count_r;
  logic [31:0] elapsed_ticks_r;
  logic        tracing_on_r;

  logic [63:0] data_table_r  [DATA_SLOTS];
  logic [63:0] range_start_r [RANGE_SLOTS];
  logic [63:0] range_end_r   [RANGE_SLOTS];

  logic        s1_valid_r;
  trace_rec_t  s1_rec_r;

  logic        trace_en;
  logic        stack_hit;
  logic        value_hit;
  logic        addr_hit;
  logic        hit;

  assign mode = mode_t'(in_mode);

  // Config registers, tick counter and tracing enable
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      monitor_stack_r  <= 1'b0;
      catch_above_r    <= '0;
      tick_threshold_r <= '0;
      data_count_r     <= '0;
      range_count_r    <= '0;
      elapsed_ticks_r  <= '0;
      tracing_on_r     <= 1'b0;
    end else begin
      if (cfg_wr) begin
        unique case (cfg_index)
          CFG_MONITOR_STACK:  monitor_stack_r  <= cfg_data[0];
          CFG_CATCH_ABOVE:    catch_above_r    <= cfg_data;
          CFG_TICK_THRESHOLD: tick_threshold_r <= cfg_data[31:0];
          CFG_DATA_COUNT:     data_count_r     <= cfg_data[3:0];
          CFG_RANGE_COUNT:    range_count_r    <= cfg_data[3:0];
          default: ;
        endcase
      end
      if (in_accept && mode == MODE_TICK) begin
        if (elapsed_ticks_r < tick_threshold_r) begin
          elapsed_ticks_r <= elapsed_ticks_r + 32'd1;
        end else begin
          tracing_on_r <= 1'b1;
        end
      end
    end
  end

  // Trigger table loads; slots beyond the table are dropped
  always_ff @(posedge clk) begin
    for (int i = 0; i < DATA_SLOTS; i++) begin
      if (in_accept && mode == MODE_LOAD_DATA && int'(in_slot) == i) begin
        data_table_r[i] <= in_access_value;
      end
    end
    for (int i = 0; i < RANGE_SLOTS; i++) begin
      if (in_accept && mode == MODE_LOAD_RANGE && int'(in_slot) == i) begin
        range_start_r[i] <= in_access_address;
        range_end_r[i]   <= in_range_end;
      end
    end
  end

  // Classifier: parallel comparators over all slots in use
  always_comb begin
    trace_en  = tracing_on_r || (tick_threshold_r == '0);
    stack_hit = monitor_stack_r &&
                (((in_stack_pointer ^ in_access_address) & ~STACK_REGION_MASK) == '0);
    value_hit = 1'b0;
    for (int i = 0; i < DATA_SLOTS; i++) begin
      if (int'(data_count_r) > i && data_table_r[i] == in_access_value) begin
        value_hit = 1'b1;
      end
    end
    addr_hit = 1'b0;
    for (int i = 0; i < RANGE_SLOTS; i++) begin
      if (int'(range_count_r) > i && range_start_r[i] <= in_access_address &&
          in_access_address <= range_end_r[i]) begin
        addr_hit = 1'b1;
      end
    end
    hit = trace_en && (in_access_address >= catch_above_r) &&
          (stack_hit || value_hit || addr_hit);
  end

  // Stage register toward the record queue
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= in_accept && mode == MODE_ACCESS && hit;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_rec_r.pc      <= in_program_counter;
      s1_rec_r.address <= in_access_address;
      s1_rec_r.value   <= in_access_value;
      s1_rec_r.write   <= in_is_write;
    end
  end

  assign q_push = {s1_valid_r, s1_rec_r};

  // Tracing never turns off once on
  a_tracing_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    tracing_on_r |=> tracing_on_r)
    else $error("tracing enable dropped");

  // A record is only pushed for an accepted access item
  a_push_from_access: assert property (@(posedge clk) disable iff (!rst_n)
    !in_accept || mode != MODE_ACCESS |=> !s1_valid_r)
    else $error("record pushed without an accepted access");

  // The tick counter moves only on an accepted tick
  a_ticks_on_tick: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_accept && mode == MODE_TICK) |=> $stable(elapsed_ticks_r))
    else $error("tick counter changed without a tick");

endmodule

`default_nettype wire

// File: hdl/mte_back.sv
// Back end: short record queue that presents the oldest trace record on
// the result channel. Depends on mte_pkg.
`default_nettype none

module mte_back (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire mte_pkg::rec_push_t q_push,
  output logic                    q_almost_full,
  output logic                    out_empty,
  input  wire logic               out_pop,
  output mte_pkg::trace_rec_t     out_rec
);
  import mte_pkg::*;

  trace_rec_t             mem_r [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr_r;
  logic [QUEUE_PTR_W-1:0] rd_ptr_r;
  logic [QUEUE_CNT_W-1:0] count_r;
  logic [QUEUE_CNT_W-1:0] count_nxt;
  logic                   pop_ok;

  assign pop_ok    = out_pop && !out_empty;
  assign out_empty = (count_r == '0);
  assign out_rec   = mem_r[rd_ptr_r];

  // Leave room for the record still in the front stage register
  assign q_almost_full = (count_r >= QUEUE_CNT_W'(QUEUE_DEPTH - 1));

  always_comb begin
    count_nxt = count_r;
    if (q_push.push && !pop_ok) begin
      count_nxt = count_r + QUEUE_CNT_W'(1);
    end else if (!q_push.push && pop_ok) begin
      count_nxt = count_r - QUEUE_CNT_W'(1);
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (q_push.push) begin
        wr_ptr_r <= wr_ptr_r + QUEUE_PTR_W'(1);
      end
      if (pop_ok) begin
        rd_ptr_r <= rd_ptr_r + QUEUE_PTR_W'(1);
      end
      count_r <= count_nxt;
    end
  end

  // Record storage
  always_ff @(posedge clk) begin
    if (q_push.push) begin
      mem_r[wr_ptr_r] <= q_push.rec;
    end
  end

  // A push never lands on a full queue unless a record is popped in the same cycle
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_push.push |-> (count_r < QUEUE_CNT_W'(QUEUE_DEPTH)) || pop_ok)
    else $error("record queue overflow");

  // Fill level stays within the queue depth
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= QUEUE_CNT_W'(QUEUE_DEPTH))
    else $error("record queue level out of range");

  // Level tracks pointer distance
  a_ptr_level: assert property (@(posedge clk) disable iff (!rst_n)
    count_r != QUEUE_CNT_W'(QUEUE_DEPTH) |->
      QUEUE_PTR_W'(count_r) == QUEUE_PTR_W'(wr_ptr_r - rd_ptr_r))
    else $error("record queue pointers disagree with level");

endmodule

`default_nettype wire

// File: hdl/memory_access_trace_trigger.sv
// Memory access trace trigger top level: front classifier plus record
// queue. Depends on mte_pkg, mte_front and mte_back.
//
// Accepts one item (access, timer tick or table load) every clock cycle while in_full is low.
// An access that triggers passes through the classifier's stage register
// and is then written into the record queue, so it shows up as a trace
// record on the out_ ports after both have been written; it then sits at the
// head of a 4-entry record queue until popped. in_full
// rises once the queue holds three records, so items keep flowing at one
// per cycle as long as records are popped as they appear. Table loads and
// ticks take effect for the very next item. The configuration port is
// always ready; write it only while no results are pending.
`default_nettype none

module memory_access_trace_trigger #(
  parameter int DATA_SLOTS  = 8,
  parameter int RANGE_SLOTS = 8
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Input channel
  input  wire logic        in_push,
  output logic             in_full,
  input  wire logic [1:0]  in_mode,
  input  wire logic [63:0] in_access_address,
  input  wire logic [63:0] in_access_value,
  input  wire logic [63:0] in_stack_pointer,
  input  wire logic [63:0] in_program_counter,
  input  wire logic        in_is_write,
  input  wire logic [2:0]  in_slot,
  input  wire logic [63:0] in_range_end,
  // Result channel
  output logic             out_empty,
  input  wire logic        out_pop,
  output logic [63:0]      out_trace_pc,
  output logic [63:0]      out_trace_address,
  output logic [63:0]      out_trace_value,
  output logic             out_trace_write,
  // Configuration write channel
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [mte_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [63:0] cfg_data
);
  import mte_pkg::*;

  logic       in_accept;
  logic       q_almost_full;
  rec_push_t  q_push;
  trace_rec_t out_rec;

  assign cfg_ready = 1'b1;
  assign in_full   = q_almost_full;
  assign in_accept = in_push && !in_full;

  // Classifier
  mte_front #(
    .DATA_SLOTS  (DATA_SLOTS),
    .RANGE_SLOTS (RANGE_SLOTS)
  ) u_front (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_accept          (in_accept),
    .in_mode            (in_mode),
    .in_access_address  (in_access_address),
    .in_access_value    (in_access_value),
    .in_stack_pointer   (in_stack_pointer),
    .in_program_counter (in_program_counter),
    .in_is_write        (in_is_write),
    .in_slot            (in_slot),
    .in_range_end       (in_range_end),
    .cfg_wr             (cfg_valid && cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .q_push             (q_push)
  );

  // Record queue and result side
  mte_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_push        (q_push),
    .q_almost_full (q_almost_full),
    .out_empty     (out_empty),
    .out_pop       (out_pop),
    .out_rec       (out_rec)
  );

  assign out_trace_pc      = out_rec.pc;
  assign out_trace_address = out_rec.address;
  assign out_trace_value   = out_rec.value;
  assign out_trace_write   = out_rec.write;

endmodule

`default_nettype wire

// File: sim/mte_checker.sv
// Checker for the memory access trace trigger: watches the item, record and config
// channels, predicts trace records and compares them in order. Depends on mte_pkg.
module mte_checker #(
  parameter int DATA_SLOTS  = 8,
  parameter int RANGE_SLOTS = 8
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_push,
  input  logic                            in_full,
  input  logic [1:0]                      in_mode,
  input  logic [63:0]                     in_access_address,
  input  logic [63:0]                     in_access_value,
  input  logic [63:0]                     in_stack_pointer,
  input  logic [63:0]                     in_program_counter,
  input  logic                            in_is_write,
  input  logic [2:0]                      in_slot,
  input  logic [63:0]                     in_range_end,
  input  logic                            out_empty,
  input  logic                            out_pop,
  input  logic [63:0]                     out_trace_pc,
  input  logic [63:0]                     out_trace_address,
  input  logic [63:0]                     out_trace_value,
  input  logic                            out_trace_write,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [mte_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [63:0]                     cfg_data,
  output int                              fail_cnt,
  output int                              pending_cnt
);
  import mte_pkg::*;

  // Register copies
  logic        stack_watch;
  logic [63:0] addr_floor;
  logic [31:0] tick_limit;
  logic [3:0]  value_trig_cnt;
  logic [3:0]  span_cnt;

  // Filter state
  logic [31:0] tick_count;
  logic        trace_armed;
  logic [63:0] value_trig [DATA_SLOTS];
  logic [63:0] span_lo    [RANGE_SLOTS];
  logic [63:0] span_hi    [RANGE_SLOTS];

  trace_rec_t  due_records[$];
  int          mismatch_total = 0;

  initial begin
    fail_cnt    = 0;
    pending_cnt = 0;
  end

  task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
    $display("[%0t] mismatch on %s: got %h, want %h", $realtime, field, got, want);
    mismatch_total++;
  endtask

  // Any of the three trigger kinds fires for this access
  function automatic logic access_traced(logic [63:0] addr, logic [63:0] val,
                                         logic [63:0] sp);
    logic hit;
    int   n_val;
    int   n_span;
    hit    = stack_watch &&
             ((sp & ~STACK_REGION_MASK) == (addr & ~STACK_REGION_MASK));
    n_val  = (value_trig_cnt > DATA_SLOTS) ? DATA_SLOTS : int'(value_trig_cnt);
    n_span = (span_cnt > RANGE_SLOTS) ? RANGE_SLOTS : int'(span_cnt);
    for (int i = 0; i < n_val; i++)
      if (value_trig[i] == val) hit = 1'b1;
    for (int i = 0; i < n_span; i++)
      if (span_lo[i] <= addr && addr <= span_hi[i]) hit = 1'b1;
    return hit;
  endfunction

  task automatic apply_reg(logic [CFG_INDEX_W-1:0] idx, logic [63:0] data);
    case (idx)
      CFG_MONITOR_STACK:  stack_watch    = data[0];
      CFG_CATCH_ABOVE:    addr_floor     = data;
      CFG_TICK_THRESHOLD: tick_limit     = data[31:0];
      CFG_DATA_COUNT:     value_trig_cnt = data[3:0];
      CFG_RANGE_COUNT:    span_cnt       = data[3:0];
      default: ;
    endcase
  endtask

  // One accepted item: update state, queue a record if the access is traced
  task automatic take_item();
    trace_rec_t rec;
    case (mode_t'(in_mode))
      MODE_TICK: begin
        if (tick_count < tick_limit) tick_count++;
        else trace_armed = 1'b1;
      end
      MODE_LOAD_DATA: begin
        if (in_slot < DATA_SLOTS) value_trig[in_slot] = in_access_value;
      end
      MODE_LOAD_RANGE: begin
        if (in_slot < RANGE_SLOTS) begin
          span_lo[in_slot] = in_access_address;
          span_hi[in_slot] = in_range_end;
        end
      end
      MODE_ACCESS: begin
        if ((trace_armed || tick_limit == '0) && in_access_address >= addr_floor &&
            access_traced(in_access_address, in_access_value, in_stack_pointer)) begin
          rec.pc      = in_program_counter;
          rec.address = in_access_address;
          rec.value   = in_access_value;
          rec.write   = in_is_write;
          due_records = {due_records, rec};
        end
      end
      default: ;
    endcase
  endtask

  // Records leave before new items are judged: none can come out in its own cycle
  always @(posedge clk) begin : watch
    trace_rec_t got;
    trace_rec_t want;
    if (!rst_n) begin
      stack_watch    = 1'b0;
      addr_floor     = '0;
      tick_limit     = '0;
      value_trig_cnt = '0;
      span_cnt       = '0;
      tick_count     = '0;
      trace_armed    = 1'b0;
      due_records.delete();
    end else begin
      if (out_pop && !out_empty) begin
        got.pc      = out_trace_pc;
        got.address = out_trace_address;
        got.value   = out_trace_value;
        got.write   = out_trace_write;
        if (due_records.size() == 0) begin
          report_mismatch("unexpected record address", got.address, '0);
        end else begin
          want = due_records.pop_front();
          if (got.pc !== want.pc) report_mismatch("trace_pc", got.pc, want.pc);
          if (got.address !== want.address)
            report_mismatch("trace_address", got.address, want.address);
          if (got.value !== want.value)
            report_mismatch("trace_value", got.value, want.value);
          if (got.write !== want.write)
            report_mismatch("trace_write", 64'(got.write), 64'(want.write));
        end
      end
      if (cfg_valid && cfg_ready) apply_reg(cfg_index, cfg_data);
      if (in_push && !in_full) take_item();
    end
    pending_cnt <= due_records.size();
    fail_cnt    <= mismatch_total;
  end

endmodule

// File: sim/tb.sv
// Testbench top for memory_access_trace_trigger: drives items, config writes and
// record pops, and gives the verdict. Depends on mte_pkg, the block RTL and mte_checker.
module tb;
  import mte_pkg::*;

  localparam int DATA_SLOTS    = 8;
  localparam int RANGE_SLOTS   = 8;
  localparam int PHASES        = 10;
  localparam int PHASE_ITEMS   = 150;
  localparam int SETTLE_CYCLES = 4;
  localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED = 3'd7;
  localparam logic [63:0] ALL_ONES = '1;
  localparam logic [63:0] NO_TRIGGER = 64'h0123_4567_89AB_CDEF;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_push = 1'b0;
  logic                   in_full;
  logic [1:0]             in_mode = MODE_ACCESS;
  logic [63:0]            in_access_address = '0;
  logic [63:0]            in_access_value = '0;
  logic [63:0]            in_stack_pointer = '0;
  logic [63:0]            in_program_counter = '0;
  logic                   in_is_write = 1'b0;
  logic [2:0]             in_slot = '0;
  logic [63:0]            in_range_end = '0;
  logic                   out_empty;
  logic                   out_pop = 1'b0;
  logic [63:0]            out_trace_pc;
  logic [63:0]            out_trace_address;
  logic [63:0]            out_trace_value;
  logic                   out_trace_write;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [63:0]            cfg_data = '0;
  int                     fail_cnt;
  int                     pending_cnt;

  logic                   idle_on = 1'b1;
  int                     pop_stall = 0;

  // What the tables hold, used to aim accesses at triggers
  logic [63:0] data_shadow     [DATA_SLOTS];
  logic [63:0] range_lo_shadow [RANGE_SLOTS];
  logic [63:0] range_hi_shadow [RANGE_SLOTS];

  memory_access_trace_trigger dut (.*);

  mte_checker #(.DATA_SLOTS(DATA_SLOTS), .RANGE_SLOTS(RANGE_SLOTS)) u_checker (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Record side: pop with random stall bursts
  always @(negedge clk) begin
    if (pop_stall != 0) begin
      pop_stall--;
      out_pop <= 1'b0;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      pop_stall = $urandom_range(1, 12) - 1;
      out_pop <= 1'b0;
    end else begin
      out_pop <= 1'b1;
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // One transaction on the item channel; push stays high on return
  task automatic send_item(mode_t md, logic [63:0] addr, logic [63:0] val,
                           logic [63:0] sp, logic [63:0] pc, logic wr,
                           logic [2:0] slot, logic [63:0] rend);
    @(negedge clk);
    in_push            <= 1'b1;
    in_mode            <= md;
    in_access_address  <= addr;
    in_access_value    <= val;
    in_stack_pointer   <= sp;
    in_program_counter <= pc;
    in_is_write        <= wr;
    in_slot            <= slot;
    in_range_end       <= rend;
    @(posedge clk);
    while (in_full) @(posedge clk);
    if (md == MODE_LOAD_DATA) data_shadow[slot] = val;
    if (md == MODE_LOAD_RANGE) begin
      range_lo_shadow[slot] = addr;
      range_hi_shadow[slot] = rend;
    end
  endtask

  task automatic send_access(logic [63:0] addr, logic [63:0] val, logic [63:0] sp);
    send_item(MODE_ACCESS, addr, val, sp, rand64(), 1'($urandom_range(0, 1)),
              3'($urandom_range(0, 7)), rand64());
  endtask

  task automatic send_tick();
    send_item(MODE_TICK, rand64(), rand64(), rand64(), rand64(),
              1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)), rand64());
  endtask

  task automatic load_data(logic [2:0] slot, logic [63:0] val);
    send_item(MODE_LOAD_DATA, rand64(), val, rand64(), rand64(),
              1'($urandom_range(0, 1)), slot, rand64());
  endtask

  task automatic load_range(logic [2:0] slot, logic [63:0] lo, logic [63:0] hi);
    send_item(MODE_LOAD_RANGE, lo, rand64(), rand64(), rand64(),
              1'($urandom_range(0, 1)), slot, hi);
  endtask

  task automatic hold_off(int cycles);
    repeat (cycles) @(negedge clk) in_push <= 1'b0;
  endtask

  // Stop sending and wait until every record is out and the pipe is quiet
  task automatic settle();
    @(negedge clk) in_push <= 1'b0;
    while (pending_cnt != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [63:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk) cfg_valid <= 1'b0;
  endtask

  task automatic program_setup(logic stack_on, logic [63:0] low_bound,
                               logic [31:0] ticks, logic [3:0] n_val, logic [3:0] n_span);
    write_reg(CFG_MONITOR_STACK, 64'(stack_on));
    write_reg(CFG_CATCH_ABOVE, low_bound);
    write_reg(CFG_TICK_THRESHOLD, 64'(ticks));
    write_reg(CFG_DATA_COUNT, 64'(n_val));
    write_reg(CFG_RANGE_COUNT, 64'(n_span));
  endtask

  // Mostly accesses aimed at range edges, stack regions and loaded values
  task automatic send_random();
    int          pick;
    int          k;
    logic [63:0] addr;
    logic [63:0] val;
    logic [63:0] sp;
    logic [63:0] rend;
    pick = $urandom_range(0, 99);
    k    = $urandom_range(0, RANGE_SLOTS - 1);
    addr = rand64();
    val  = rand64();
    sp   = rand64();
    rend = rand64();
    if (pick < 60) begin
      case ($urandom_range(0, 5))
        0: addr = range_lo_shadow[k];
        1: addr = range_hi_shadow[k];
        2: addr = range_lo_shadow[k] - 64'd1;
        3: addr = range_hi_shadow[k] + 64'd1;
        4: addr = {sp[63:18], addr[17:0]};
        default: ;
      endcase
      if ($urandom_range(0, 1) == 1) val = data_shadow[$urandom_range(0, DATA_SLOTS - 1)];
      send_access(addr, val, sp);
    end else if (pick < 75) begin
      send_tick();
    end else if (pick < 87) begin
      case ($urandom_range(0, 3))
        0: val = '0;
        1: val = ALL_ONES;
        default: ;
      endcase
      load_data(3'($urandom_range(0, DATA_SLOTS - 1)), val);
    end else begin
      case ($urandom_range(0, 3))
        0: rend = addr;
        1: rend = addr + 64'($urandom_range(0, 4095));
        2: rend = addr - 64'($urandom_range(1, 4095));
        default: ;
      endcase
      load_range(3'($urandom_range(0, RANGE_SLOTS - 1)), addr, rend);
    end
  endtask

  initial begin
    logic [63:0] low_bound;
    int          k;
    repeat (3) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // Fill every slot before any count enables it
    load_data(3'd0, '0);
    load_data(3'd1, ALL_ONES);
    load_data(3'd2, 64'h8000_0000_0000_0000);
    load_data(3'd3, 64'h0000_0000_0000_0001);
    load_data(3'd4, 64'h5555_5555_5555_5555);
    load_data(3'd5, 64'hAAAA_AAAA_AAAA_AAAA);
    for (int i = 6; i < DATA_SLOTS; i++) load_data(3'(i), rand64());
    load_range(3'd0, 64'h1000, 64'h1FFF);
    load_range(3'd1, 64'h4_0000_0000, 64'h4_0000_0000);   // single value
    load_range(3'd2, 64'h9000, 64'h8000);                 // reversed, never matches
    load_range(3'd3, '0, 64'h10);
    load_range(3'd4, 64'hFFFF_FFFF_FFFF_FFF0, ALL_ONES);
    for (int i = 5; i < RANGE_SLOTS; i++) begin
      low_bound = rand64();
      load_range(3'(i), low_bound, low_bound + 64'($urandom_range(0, 255)));
    end

    // Directed: tracing arms on the tick after the threshold count
    settle();
    program_setup(1'b1, '0, 32'd2, 4'd8, 4'd8);
    write_reg(CFG_UNUSED, rand64());
    send_tick();
    send_tick();
    send_access(64'h7FFF_0000_0007_FFF8, NO_TRIGGER, 64'h7FFF_0000_0004_0000);
    send_tick();
    send_access(64'h7FFF_0000_0007_FFF8, NO_TRIGGER, 64'h7FFF_0000_0004_0000);
    send_access(64'h0000_1234_5670_0000, '0, rand64());
    send_access(64'h0000_1234_5670_0000, ALL_ONES, rand64());
    send_access(64'h1000, NO_TRIGGER, rand64());
    send_access(64'h1FFF, NO_TRIGGER, rand64());
    send_access(64'h4_0000_0000, NO_TRIGGER, rand64());
    send_access(64'h8800, NO_TRIGGER, rand64());

    // Random phases, each under its own register setting
    for (int p = 0; p < PHASES; p++) begin
      settle();
      idle_on = (p != PHASES - 1) && (p % 4 != 3);
      k = $urandom_range(0, RANGE_SLOTS - 1);
      case ($urandom_range(0, 2))
        0: low_bound = '0;
        1: low_bound = range_lo_shadow[k];
        default: low_bound = rand64();
      endcase
      case (p)
        0: program_setup(1'b0, '0, ALL_ONES[31:0], 4'd8, 4'd8);
        1: program_setup(1'b1, '0, 32'd40, 4'd15, 4'd15);
        2: program_setup(1'b1, ALL_ONES, '0, 4'd0, 4'd8);
        3: program_setup(1'b1, '0, '0, 4'd0, 4'd0);
        default: program_setup(1'($urandom_range(0, 1)), low_bound,
                               ($urandom_range(0, 1) == 1) ? 32'd0 : $urandom,
                               4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)));
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (idle_on && $urandom_range(0, 5) == 0) hold_off($urandom_range(1, 12));
        send_random();
      end
    end
    settle();

    if (fail_cnt == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
